[rtl/mdp_pkg.sv]
// Package for the masked depth-to-point back-projection block.
// Holds the fixed-point widths, register codes and stage-enable type.
// No dependencies; used by mdp_axis and masked_depth_to_point.
package mdp_pkg;

  // Fixed-point configuration
  localparam int COORD_BITS          = 12;
  localparam int INV_FOCAL_FRAC_BITS = 24;

  // Field widths fixed by the interface
  localparam int ROW_W    = 12;
  localparam int COL_W    = 12;
  localparam int DEPTH_W  = 16;
  localparam int CENTRE_W = 16;
  localparam int INV_W    = 24;
  localparam int POS_W    = 37;
  localparam int CFG_W    = 24;

  // Derived datapath widths
  localparam int C16_W     = COORD_BITS + 4;
  localparam int MAG_W     = (C16_W > CENTRE_W) ? C16_W : CENTRE_W;
  localparam int PD_W      = MAG_W + DEPTH_W;
  localparam int PROD_W    = PD_W + INV_W;
  localparam int SPROD_W   = PROD_W + 1;
  localparam int POS_SHIFT = INV_FOCAL_FRAC_BITS - 4;

  // Stream payload widths (padded to whole bytes)
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 112;
  localparam int M_PAD_W   = M_TDATA_W - (2 * POS_W + 2 * DEPTH_W);

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_CENTER_X  = 2'd0,
    CFG_CENTER_Y  = 2'd1,
    CFG_INV_FOC_X = 2'd2,
    CFG_INV_FOC_Y = 2'd3
  } cfg_reg_e;

  // Load enables for the four pipeline stages
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } mdp_stage_en_t;

endpackage

[rtl/masked_depth_to_point.sv]
// Top level of the masked depth-to-point back-projection block.
// Holds the configuration registers, the valid/stall control and both axes.
// Depends on mdp_pkg and mdp_axis.
//
// Takes one depth pixel per clock while s_axis_tready is high and returns one
// point per kept pixel; pixels with the mask bit clear are dropped at the
// input and produce no point at the output. Each axis has a four-stage
// datapath: offset, depth multiply, inverse-focal multiply, and the signed
// floor shift that lands in the output register.
// Any stage holding no point is refilled while the output waits, so input
// ready only falls when all four stages are full and the output is stalled.
// A zero depth gives a point with the valid flag clear and all fields zero.
// Configuration writes are taken at any cycle and should be made while no
// pixel is in flight.
module masked_depth_to_point (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write port
  input  logic                            cfg_we_i,
  input  logic [1:0]                      cfg_idx_i,
  input  logic [mdp_pkg::CFG_W-1:0]       cfg_wdata_i,
  // Pixel stream in
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [11:0] pixel_row, [23:12] pixel_col, [39:24] depth_mm
  input  logic [mdp_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // [0] in_region
  input  logic                            s_axis_tuser,
  // Point stream out
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [36:0] x_pos, [73:37] y_pos, [89:74] z_mm, [105:90] intensity, rest zero
  output logic [mdp_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  // [0] point_valid
  output logic                            m_axis_tuser
);
  import mdp_pkg::*;

  logic [CENTRE_W-1:0]     center_x_q, center_y_q;
  logic [INV_W-1:0]        inv_focal_x_q, inv_focal_y_q;
  logic [4:1]              vld_q;
  logic [4:1]              rdy;
  mdp_stage_en_t           en;
  logic [DEPTH_W-1:0]      depth1_q, depth2_q, depth3_q, depth4_q;
  logic [ROW_W-1:0]        row_in;
  logic [COL_W-1:0]        col_in;
  logic                    pv4_q;
  logic signed [POS_W-1:0] x_pos, y_pos;

  assign row_in = s_axis_tdata[11:0];
  assign col_in = s_axis_tdata[23:12];

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q    <= CENTRE_W'(5120);
      center_y_q    <= CENTRE_W'(3840);
      inv_focal_x_q <= INV_W'(31957);
      inv_focal_y_q <= INV_W'(31957);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_CENTER_X:  center_x_q    <= cfg_wdata_i[CENTRE_W-1:0];
        CFG_CENTER_Y:  center_y_q    <= cfg_wdata_i[CENTRE_W-1:0];
        CFG_INV_FOC_X: inv_focal_x_q <= cfg_wdata_i[INV_W-1:0];
        CFG_INV_FOC_Y: inv_focal_y_q <= cfg_wdata_i[INV_W-1:0];
        default: ;
      endcase
    end
  end

  // A stage loads when it is empty or its successor moves on
  always_comb begin
    rdy[4] = !vld_q[4] || m_axis_tready;
    rdy[3] = !vld_q[3] || rdy[4];
    rdy[2] = !vld_q[2] || rdy[3];
    rdy[1] = !vld_q[1] || rdy[2];
    en.s1  = rdy[1];
    en.s2  = rdy[2];
    en.s3  = rdy[3];
    en.s4  = rdy[4];
  end

  assign s_axis_tready = rdy[1];

  // Valid bits; masked pixels never enter stage 1
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[1]) vld_q[1] <= s_axis_tvalid && s_axis_tuser;
      if (rdy[2]) vld_q[2] <= vld_q[1];
      if (rdy[3]) vld_q[3] <= vld_q[2];
      if (rdy[4]) vld_q[4] <= vld_q[3];
    end
  end

  // Depth travels alongside the axis datapaths
  always_ff @(posedge clk_i) begin
    if (rdy[1]) depth1_q <= s_axis_tdata[39:24];
    if (rdy[2]) depth2_q <= depth1_q;
    if (rdy[3]) depth3_q <= depth2_q;
    if (rdy[4]) begin
      depth4_q <= depth3_q;
      pv4_q    <= (depth3_q != '0);
    end
  end

  mdp_axis u_axis_x (
    .clk_i       (clk_i),
    .en_i        (en),
    .coord_i     (col_in),
    .centre_i    (center_x_q),
    .inv_focal_i (inv_focal_x_q),
    .depth_s1_i  (depth1_q),
    .pos_o       (x_pos)
  );

  mdp_axis u_axis_y (
    .clk_i       (clk_i),
    .en_i        (en),
    .coord_i     (row_in),
    .centre_i    (center_y_q),
    .inv_focal_i (inv_focal_y_q),
    .depth_s1_i  (depth1_q),
    .pos_o       (y_pos)
  );

  // Output transaction
  assign m_axis_tvalid = vld_q[4];
  assign m_axis_tuser  = pv4_q;
  assign m_axis_tdata  = {{M_PAD_W{1'b0}}, depth4_q, depth4_q, y_pos, x_pos};

  // Checks
  a_empty_out_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while output stage empty");

  a_masked_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !s_axis_tuser |=> !vld_q[1])
    else $error("masked pixel entered the pipeline");

  a_flag_matches_z: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == (m_axis_tdata[89:74] != '0)))
    else $error("point_valid disagrees with depth");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> (x_pos == '0) && (y_pos == '0))
    else $error("zero-depth point has non-zero coordinates");

endmodule

[rtl/mdp_axis.sv]
// One axis of the back-projection datapath: offset, two multiplies, floor shift.
// Four register stages, each loaded by its enable from the top level.
// Depends on mdp_pkg.
module mdp_axis (
  input  logic                           clk_i,
  input  mdp_pkg::mdp_stage_en_t         en_i,
  input  logic [11:0]                    coord_i,
  input  logic [mdp_pkg::CENTRE_W-1:0]   centre_i,
  input  logic [mdp_pkg::INV_W-1:0]      inv_focal_i,
  input  logic [mdp_pkg::DEPTH_W-1:0]    depth_s1_i,
  output logic signed [mdp_pkg::POS_W-1:0] pos_o
);
  import mdp_pkg::*;

  logic [C16_W-1:0]          c16;
  logic [MAG_W:0]            diff;
  logic                      neg_d;
  logic [MAG_W-1:0]          mag_d;
  logic                      neg1_q, neg2_q, neg3_q;
  logic [MAG_W-1:0]          mag_q;
  logic [PD_W-1:0]           pd_d, pd_q;
  logic [PROD_W-1:0]         prod_d, prod_q;
  logic signed [SPROD_W-1:0] sprod;
  logic signed [SPROD_W-1:0] shifted;
  logic signed [POS_W-1:0]   pos_d, pos_q;

  // Stage 1: signed offset from the principal point, as sign and magnitude
  always_comb begin
    c16   = {COORD_BITS'(coord_i), 4'b0000};
    diff  = (MAG_W + 1)'(c16) - (MAG_W + 1)'(centre_i);
    neg_d = diff[MAG_W];
    mag_d = neg_d ? MAG_W'(-diff) : diff[MAG_W-1:0];
  end

  // Stage 2: magnitude times depth
  assign pd_d = PD_W'(mag_q) * PD_W'(depth_s1_i);

  // Stage 3: times inverse focal length
  assign prod_d = PROD_W'(pd_q) * PROD_W'(inv_focal_i);

  // Stage 4: apply sign, then arithmetic shift gives floor rounding
  always_comb begin
    sprod = $signed({1'b0, prod_q});
    if (neg3_q) begin
      sprod = -sprod;
    end
    shifted = sprod >>> POS_SHIFT;
    pos_d   = shifted[POS_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      neg1_q <= neg_d;
      mag_q  <= mag_d;
    end
    if (en_i.s2) begin
      neg2_q <= neg1_q;
      pd_q   <= pd_d;
    end
    if (en_i.s3) begin
      neg3_q <= neg2_q;
      prod_q <= prod_d;
    end
    if (en_i.s4) begin
      pos_q <= pos_d;
    end
  end

  assign pos_o = pos_q;

endmodule
